### src/sspbd_pkg.sv
// Constants shared by the sync-word correlator deframer, its interfaces and its checker.
package sspbd_pkg;

  localparam int unsigned RX_W     = 8;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned SHIFT_W  = 32;
  localparam int unsigned PHASE_W  = 4;

  localparam logic [SHIFT_W-1:0] SYNC_A      = 32'h6566_A5AA;
  localparam logic [SHIFT_W-1:0] SYNC_B      = 32'h9A99_5A55;
  localparam logic [IDX_W-1:0]   FRAME_BYTES = 6'd33;

  typedef logic [RX_W-1:0]  data_t;
  typedef logic [IDX_W-1:0] idx_t;

endpackage

### src/sspbd_if.sv
// Valid/ready channel interfaces for the raw byte input and the decoded byte output.
interface sspbd_in_if;
  import sspbd_pkg::*;

  logic  valid;
  logic  ready;
  data_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sspbd_out_if;
  import sspbd_pkg::*;

  logic  valid;
  logic  ready;
  data_t frame_byte;
  idx_t  byte_index;
  logic  last_of_frame;
  logic  polarity_inverted;

  modport source (output valid, output frame_byte, output byte_index, output last_of_frame,
                  output polarity_inverted, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input last_of_frame,
                  input polarity_inverted, output ready);
endinterface

### src/sync_search_pair_bit_deframer.sv
// Sync-word correlator and pair-bit deframer top level.
// A decoded byte appears on the output in the cycle after the input transaction that
// completes it. Throughput: one input transaction per cycle while the output register is
// empty or being taken; the eight bit steps of a byte are resolved in one pass of logic
// ahead of the state and output registers. Reset: synchronous, active low; the correlator
// clears, searching resumes and the output register empties.
module sync_search_pair_bit_deframer (
  input  logic               clk,
  input  logic               rst_n,
  sspbd_in_if.sink           in_ch,
  sspbd_out_if.source        out_ch
);
  import sspbd_pkg::*;

  logic [SHIFT_W-1:0] line_shift_r, line_shift_nxt;
  logic [PHASE_W-1:0] pair_phase_r, pair_phase_nxt;
  data_t              byte_accum_r, byte_accum_nxt;
  logic               searching_r, searching_nxt;
  idx_t               byte_position_r, byte_position_nxt;
  logic               inverted_r, inverted_nxt;

  logic               res_hit;
  data_t              res_byte;
  idx_t               res_idx;
  logic               res_last;
  logic               res_pol;

  logic               out_valid_r;
  data_t              out_byte_r;
  idx_t               out_idx_r;
  logic               out_last_r;
  logic               out_pol_r;

  logic               in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    logic bit_v;
    line_shift_nxt    = line_shift_r;
    pair_phase_nxt    = pair_phase_r;
    byte_accum_nxt    = byte_accum_r;
    searching_nxt     = searching_r;
    byte_position_nxt = byte_position_r;
    inverted_nxt      = inverted_r;
    res_hit           = 1'b0;
    res_byte          = '0;
    res_idx           = '0;
    res_last          = 1'b0;
    res_pol           = 1'b0;
    for (int k = 0; k < RX_W; k++) begin
      bit_v          = in_ch.rx_byte[RX_W-1-k];
      line_shift_nxt = {line_shift_nxt[SHIFT_W-2:0], bit_v};
      if (!pair_phase_nxt[0]) begin
        byte_accum_nxt = {byte_accum_nxt[RX_W-2:0], bit_v};
      end
      if (searching_nxt) begin
        if (line_shift_nxt == SYNC_A || line_shift_nxt == SYNC_B) begin
          searching_nxt     = 1'b0;
          pair_phase_nxt    = '0;
          byte_position_nxt = '0;
          byte_accum_nxt    = '0;
          inverted_nxt      = (line_shift_nxt == SYNC_A);
        end
      end else begin
        pair_phase_nxt = pair_phase_nxt + 4'd1;
        if (pair_phase_nxt == '0) begin
          if (inverted_nxt) begin
            byte_accum_nxt = ~byte_accum_nxt;
          end
          res_idx           = byte_position_nxt;
          byte_position_nxt = byte_position_nxt + 6'd1;
          res_last          = (byte_position_nxt >= FRAME_BYTES);
          if (res_last) begin
            searching_nxt = 1'b1;
          end
          res_hit  = 1'b1;
          res_byte = byte_accum_nxt;
          res_pol  = inverted_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_shift_r    <= '0;
      pair_phase_r    <= '0;
      byte_accum_r    <= '0;
      searching_r     <= 1'b1;
      byte_position_r <= '0;
      inverted_r      <= 1'b0;
    end else if (in_fire) begin
      line_shift_r    <= line_shift_nxt;
      pair_phase_r    <= pair_phase_nxt;
      byte_accum_r    <= byte_accum_nxt;
      searching_r     <= searching_nxt;
      byte_position_r <= byte_position_nxt;
      inverted_r      <= inverted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res_hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_hit) begin
      out_byte_r <= res_byte;
      out_idx_r  <= res_idx;
      out_last_r <= res_last;
      out_pol_r  <= res_pol;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.frame_byte        = out_byte_r;
  assign out_ch.byte_index        = out_idx_r;
  assign out_ch.last_of_frame     = out_last_r;
  assign out_ch.polarity_inverted = out_pol_r;

endmodule

### src/sspbd_checker.sv
// Port-level assertions for the deframer and the bind that attaches them to it.
module sspbd_checker (
  input  logic          clk,
  input  logic          rst_n,
  sspbd_in_if.sink      in_ch,
  sspbd_out_if.source   out_ch
);
  import sspbd_pkg::*;

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("Output valid after reset.");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.frame_byte)
      && $stable(out_ch.byte_index))
    else $error("Stalled output transaction changed.");

  a_caused_by_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready))
    else $error("Output transaction without an input transaction.");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_of_frame |-> out_ch.byte_index == FRAME_BYTES - 6'd1)
    else $error("Frame end at wrong byte index.");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("Input stalled with an empty output register.");

endmodule

bind sync_search_pair_bit_deframer sspbd_checker u_sspbd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

### tb/sv/sync_search_pair_bit_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench that feeds line bytes to the deframer and checks each decoded byte.
module sync_search_pair_bit_deframer_tb;
  import sspbd_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    data_t frame_byte;
    idx_t  byte_index;
    logic  last_of_frame;
    logic  polarity_inverted;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_ready = 1'b0;

  sspbd_in_if  in_ch();
  sspbd_out_if out_ch();

  sync_search_pair_bit_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  assign out_ch.ready = rx_ready;

  always #10 clk = ~clk;

  // Decoder state mirrored from the block.
  logic [SHIFT_W-1:0] corr_reg;
  logic [PHASE_W-1:0] phase_cnt;
  data_t              data_shift;
  logic               hunting;
  idx_t               pos_cnt;
  logic               flip;

  frame_byte_t pending_bytes[$];
  bit          line_bits[$];

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 68;
  int unsigned items_sent    = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_token    = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  task automatic decode_rx_byte(input data_t raw);
    logic        bit_in;
    logic        emitted;
    frame_byte_t rec;
    emitted = 1'b0;
    rec = '0;
    for (int k = RX_W - 1; k >= 0; k--) begin
      bit_in = raw[k];
      corr_reg = {corr_reg[SHIFT_W-2:0], bit_in};
      if (!phase_cnt[0]) begin
        data_shift = {data_shift[RX_W-2:0], bit_in};
      end
      if (hunting) begin
        if (corr_reg == SYNC_A || corr_reg == SYNC_B) begin
          hunting    = 1'b0;
          phase_cnt  = '0;
          pos_cnt    = '0;
          data_shift = '0;
          flip       = (corr_reg == SYNC_A);
        end
      end else begin
        phase_cnt = phase_cnt + 4'd1;
        if (phase_cnt == '0) begin
          rec.byte_index = pos_cnt;
          if (flip) begin
            data_shift = ~data_shift;
          end
          pos_cnt = pos_cnt + 6'd1;
          rec.last_of_frame = (pos_cnt >= FRAME_BYTES);
          if (rec.last_of_frame) begin
            hunting = 1'b1;
          end
          if (!emitted) begin
            rec.frame_byte        = data_shift;
            rec.polarity_inverted = flip;
            pending_bytes.push_back(rec);
            emitted = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic send_byte(input data_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_rx_byte(b);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) line_bits.push_back(v[i]);
  endtask

  // Line coding: each data bit is followed by its complement, sometimes by a random bit.
  task automatic queue_data_byte();
    bit d;
    for (int i = 0; i < RX_W; i++) begin
      d = 1'($urandom_range(0, 1));
      line_bits.push_back(d);
      if ($urandom_range(0, 7) == 0) line_bits.push_back(1'($urandom_range(0, 1)));
      else line_bits.push_back(~d);
    end
  endtask

  task automatic flush_line_bits();
    data_t b;
    while (line_bits.size() >= RX_W) begin
      for (int i = RX_W - 1; i >= 0; i--) b[i] = line_bits.pop_front();
      send_byte(b);
    end
  endtask

  task automatic send_frame(input bit use_a, input int n_data, input bit corrupt);
    logic [31:0] word;
    word = use_a ? SYNC_A : SYNC_B;
    if (corrupt) word = word ^ (32'd1 << $urandom_range(0, 31));
    queue_bits($urandom, $urandom_range(0, 15));
    queue_bits(word, SHIFT_W);
    repeat (n_data) queue_data_byte();
    flush_line_bits();
  endtask

  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(data_t'($urandom));
      end else if (pick == 1) begin
        send_frame(1'($urandom_range(0, 1)), int'(FRAME_BYTES), 1'b1);
      end else if (pick == 2) begin
        send_frame(1'($urandom_range(0, 1)), $urandom_range(1, 6), 1'b0);
      end else begin
        send_frame(1'($urandom_range(0, 1)), int'(FRAME_BYTES), 1'b0);
      end
    end
  endtask

  task automatic test_field_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
  endtask

  task automatic test_sync_a_offset();
    queue_bits($urandom, 3);
    queue_bits(SYNC_A, SHIFT_W);
    repeat (3) queue_data_byte();
    flush_line_bits();
  endtask

  task automatic test_traffic_phase(input int unsigned s_pct, input int unsigned r_pct,
                                    input int unsigned n_items);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    run_random_traffic(n_items);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    hold_token <= hold_token + 1;
    send_frame(1'($urandom_range(0, 1)), int'(FRAME_BYTES), 1'b0);
    send_frame(1'($urandom_range(0, 1)), int'(FRAME_BYTES), 1'b0);
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rx_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected transaction: byte %h index %0d last %b pol %b",
                   out_ch.frame_byte, out_ch.byte_index, out_ch.last_of_frame,
                   out_ch.polarity_inverted);
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.frame_byte !== want.frame_byte || out_ch.byte_index !== want.byte_index ||
            out_ch.last_of_frame !== want.last_of_frame ||
            out_ch.polarity_inverted !== want.polarity_inverted) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"Mismatch: expected byte %h index %0d last %b pol %b, ",
                      "got byte %h index %0d last %b pol %b"},
                     want.frame_byte, want.byte_index, want.last_of_frame,
                     want.polarity_inverted, out_ch.frame_byte, out_ch.byte_index,
                     out_ch.last_of_frame, out_ch.polarity_inverted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    rst_n         <= 1'b0;
    corr_reg   = '0;
    phase_cnt  = '0;
    data_shift = '0;
    hunting    = 1'b1;
    pos_cnt    = '0;
    flip       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_sync_a_offset();
    wait_for_results();
    test_traffic_phase(33, 68, 330);
    test_traffic_phase(68, 33, 330);
    test_traffic_phase(0, 0, 230);
    test_output_backpressure();

    if (pending_bytes.size() != 0) begin
      mismatches++;
      $display("%0d expected transactions never arrived", pending_bytes.size());
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sync_search_pair_bit_deframer.f
src/sspbd_pkg.sv
src/sspbd_if.sv
src/sync_search_pair_bit_deframer.sv
src/sspbd_checker.sv
tb/sv/sync_search_pair_bit_deframer_tb.sv
